>>> design/parametric_surface_vertex_assert.svh
// Assertion macros shared by the parametric surface vertex design.
`ifndef PARAMETRIC_SURFACE_VERTEX_ASSERT_SVH
`define PARAMETRIC_SURFACE_VERTEX_ASSERT_SVH
`ifndef SYNTHESIS
`define PSV_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("psv assertion failed");
`define PSV_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("psv assertion failed");
`else
`define PSV_ASSERT_IMP(label, clk, rst_n, pre, post)
`define PSV_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> design/psv_pkg.sv
// Shared types, constants and rounding helpers for the parametric surface vertex design.
package psv_pkg;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_GRID     = 256;
    localparam int CORDIC_STEPS = 16;
    localparam int GRID_W       = 9;
    localparam int CFG_W        = 24;
    localparam int POS_W        = 26;
    localparam int NRM_W        = 18;
    localparam int TEX_W        = 17;
    localparam int SLOT_W       = 17;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 184;

    // Divider chain lengths (one cell per numerator bit).
    localparam int DIV_M_W    = 11;
    localparam int DIV_Z_W    = 25;
    localparam int LIN_NUM_W  = 34;
    localparam int TEX_NUM_W  = 25;
    localparam int TRIG_LAT   = DIV_M_W + 1 + DIV_Z_W + CORDIC_STEPS + 1;

    localparam logic signed [31:0]     CORDIC_K   = 32'sd652032875;
    localparam logic [16:0]            HALFPI_Q16 = 17'd102944;
    localparam logic signed [NRM_W-1:0] ONE_Q     = 18'sd65536;
    localparam logic [TEX_W-1:0]       TEX_ONE    = 17'd65536;
    localparam logic [SLOT_W-1:0]      SLOT_MAX   = 17'h1FFFF;
    localparam logic signed [63:0]     POS_MAX    = 64'sd33554431;
    localparam logic signed [63:0]     POS_MIN    = -64'sd33554432;

    localparam logic signed [18:0] ATAN_Q16 [CORDIC_STEPS] = '{
        19'sd51472, 19'sd30386, 19'sd16055, 19'sd8150, 19'sd4091, 19'sd2047,
        19'sd1024, 19'sd512, 19'sd256, 19'sd128, 19'sd64, 19'sd32, 19'sd16,
        19'sd8, 19'sd4, 19'sd2
    };

    localparam logic [1:0] KIND_SPHERE = 2'd0;
    localparam logic [1:0] KIND_TORUS  = 2'd1;
    localparam logic [1:0] KIND_TUBE   = 2'd2;
    localparam logic [1:0] KIND_PLANE  = 2'd3;

    localparam logic [2:0] CFG_KIND = 3'd0;
    localparam logic [2:0] CFG_COLS = 3'd1;
    localparam logic [2:0] CFG_ROWS = 3'd2;
    localparam logic [2:0] CFG_RAD  = 3'd3;
    localparam logic [2:0] CFG_SEC  = 3'd4;

    typedef logic signed [NRM_W-1:0] t_nrm;

    // Shift right by n with rounding to nearest, ties away from zero.
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned n);
        logic signed [63:0] half;
        half = 64'sd1 <<< (n - 1);
        if (v >= 0) begin
            return (v + half) >>> n;
        end
        return -((-v + half) >>> n);
    endfunction

    function automatic logic signed [63:0] mulq(input logic signed [63:0] p);
        return rnd_shr(p, FRAC_BITS);
    endfunction

    function automatic t_nrm clamp_nrm(input logic signed [63:0] v);
        if (v > 64'sd65536) begin
            return ONE_Q;
        end
        if (v < -64'sd65536) begin
            return -ONE_Q;
        end
        return v[NRM_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [63:0] v);
        if (v > POS_MAX) begin
            return POS_MAX[POS_W-1:0];
        end
        if (v < POS_MIN) begin
            return POS_MIN[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction
endpackage

>>> design/psv_delay.sv
// Enable-gated shift line that keeps side data aligned with the pipeline.
module psv_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

>>> design/psv_div.sv
// Pipelined restoring divider: a chain of cells, one quotient bit per cell.
module psv_div #(
    parameter int NUM_W = 11,
    parameter int DEN_W = 9
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem,
    output logic [DEN_W-1:0] o_den
);
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_cell
        logic [DEN_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [NUM_W-1:0] w_num_in;
        logic [NUM_W-1:0] w_quo_in;
        logic [DEN_W:0]   w_trial;
        logic             w_fit;
        logic [DEN_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_den_in = i_den;
            assign w_num_in = i_num;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_num_in = r_num[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_trial = {w_rem_in, w_num_in[NUM_W-1]};
        assign w_fit   = (w_trial >= {1'b0, w_den_in});
        assign n_rem   = w_fit ? DEN_W'(w_trial - {1'b0, w_den_in}) : w_trial[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den_in;
                r_num[k] <= {w_num_in[NUM_W-2:0], 1'b0};
                r_quo[k] <= {w_quo_in[NUM_W-2:0], w_fit};
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];
    assign o_rem = r_rem[NUM_W-1];
    assign o_den = r_den[NUM_W-1];
endmodule

>>> design/psv_cordic.sv
// Rotation-mode CORDIC as a chain of cells, one micro-rotation per cell.
module psv_cordic
    import psv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [18:0] i_z,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y
);
    logic signed [31:0] r_x [CORDIC_STEPS];
    logic signed [31:0] r_y [CORDIC_STEPS];
    logic signed [18:0] r_z [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        logic signed [31:0] w_x;
        logic signed [31:0] w_y;
        logic signed [18:0] w_z;
        logic signed [31:0] w_dx;
        logic signed [31:0] w_dy;

        if (k == 0) begin : g_first
            assign w_x = CORDIC_K;
            assign w_y = '0;
            assign w_z = i_z;
        end else begin : g_next
            assign w_x = r_x[k-1];
            assign w_y = r_y[k-1];
            assign w_z = r_z[k-1];
        end

        assign w_dx = w_y >>> k;
        assign w_dy = w_x >>> k;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_z >= 0) begin
                    r_x[k] <= w_x - w_dx;
                    r_y[k] <= w_y + w_dy;
                    r_z[k] <= w_z - ATAN_Q16[k];
                end else begin
                    r_x[k] <= w_x + w_dx;
                    r_y[k] <= w_y - w_dy;
                    r_z[k] <= w_z + ATAN_Q16[k];
                end
            end
        end
    end

    assign o_x = r_x[CORDIC_STEPS-1];
    assign o_y = r_y[CORDIC_STEPS-1];
endmodule

>>> design/psv_trig.sv
// Cosine and sine of a quarter-turn fraction m/den: quadrant split, angle scale, CORDIC.
module psv_trig
    import psv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [DIV_M_W-1:0] i_m,
    input  logic [GRID_W-1:0]  i_den,
    output t_nrm               o_cos,
    output t_nrm               o_sin
);
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    logic [DIV_M_W-1:0] w_quo_a;
    logic [GRID_W-1:0]  w_rem_a;
    logic [GRID_W-1:0]  w_den_a;
    logic [25:0]        w_zprod;
    logic [DIV_Z_W-1:0] r_znum;
    logic [GRID_W-1:0]  r_zden;
    logic [1:0]         r_q;
    logic [1:0]         w_q_d;
    logic [DIV_Z_W-1:0] w_quo_b;
    logic signed [18:0] w_z;
    logic signed [31:0] w_x;
    logic signed [31:0] w_y;
    t_nrm               w_cc;
    t_nrm               w_ss;
    t_nrm               r_cos;
    t_nrm               r_sin;

    psv_div #(.NUM_W(DIV_M_W), .DEN_W(GRID_W)) u_div_quad (
        .i_clk(i_clk), .i_en(i_en), .i_num(i_m), .i_den(i_den),
        .o_quo(w_quo_a), .o_rem(w_rem_a), .o_den(w_den_a)
    );

    assign w_zprod = w_rem_a * HALFPI_Q16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_znum <= w_zprod[DIV_Z_W-1:0] + DIV_Z_W'(w_den_a >> 1);
            r_zden <= w_den_a;
            r_q    <= w_quo_a[1:0];
        end
    end

    psv_div #(.NUM_W(DIV_Z_W), .DEN_W(GRID_W)) u_div_ang (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_znum), .i_den(r_zden),
        .o_quo(w_quo_b), .o_rem(), .o_den()
    );

    psv_delay #(.WIDTH(2), .DEPTH(DIV_Z_W + CORDIC_STEPS)) u_dly_quad (
        .i_clk(i_clk), .i_en(i_en), .i_d(r_q), .o_q(w_q_d)
    );

    assign w_z = $signed({2'b00, w_quo_b[16:0]});

    psv_cordic u_cordic (
        .i_clk(i_clk), .i_en(i_en), .i_z(w_z), .o_x(w_x), .o_y(w_y)
    );

    assign w_cc = clamp_nrm(rnd_shr(w_x, 30 - FRAC_BITS));
    assign w_ss = clamp_nrm(rnd_shr(w_y, 30 - FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (w_q_d)
                QUAD_I: begin
                    r_cos <= w_cc;
                    r_sin <= w_ss;
                end
                QUAD_II: begin
                    r_cos <= -w_ss;
                    r_sin <= w_cc;
                end
                QUAD_III: begin
                    r_cos <= -w_cc;
                    r_sin <= -w_ss;
                end
                QUAD_IV: begin
                    r_cos <= w_ss;
                    r_sin <= -w_cc;
                end
                default: begin
                    r_cos <= w_cc;
                    r_sin <= w_ss;
                end
            endcase
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

>>> design/parametric_surface_vertex.sv
// Top level: grid point in, surface vertex out, for sphere, torus, tube and plane.
//
//  channel   dir  handshake                  payload
//  s_axis    in   i_s_axis_tvalid/o_..tready tdata: grid_column, grid_row
//  m_axis    out  o_m_axis_tvalid/i_..tready tdata: pos, nrm, tex, slot; tuser: config_error
//  cfg       in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One beat is taken every cycle while the skid register is empty; a result passes the
// input register, the divider cell chains, the 16 CORDIC cells and the product stages.
// Reset clears the configuration to its defaults and empties the pipeline; no sweep.
// The pipeline stalls only when both the output register and its skid register are full.
`include "parametric_surface_vertex_assert.svh"
module parametric_surface_vertex
    import psv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata from bit 0: grid_column[8:0], grid_row[17:9], zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata from bit 0: pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v,
    // vertex_slot, zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: config_error
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);
    localparam int T_M2     = TRIG_LAT + 2;
    localparam int P_LAT    = TRIG_LAT + 3;
    localparam int SIDE_DLY = T_M2 - 1;
    localparam int LIN_DLY  = T_M2 - 1 - LIN_NUM_W;
    localparam int TEX_DLY  = T_M2 - 1 - TEX_NUM_W;
    localparam int SIDE_W   = 2 + SLOT_W;

    // Configuration registers
    logic [1:0]        r_kind;
    logic [GRID_W-1:0] r_cols;
    logic [GRID_W-1:0] r_rows;
    logic [CFG_W-1:0]  r_rad;
    logic [CFG_W-1:0]  r_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_SPHERE;
            r_cols <= 9'd3;
            r_rows <= 9'd2;
            r_rad  <= 24'd65536;
            r_sec  <= 24'd32768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KIND: r_kind <= i_cfg_data[1:0];
                CFG_COLS: r_cols <= i_cfg_data[GRID_W-1:0];
                CFG_ROWS: r_rows <= i_cfg_data[GRID_W-1:0];
                CFG_RAD:  r_rad  <= i_cfg_data;
                CFG_SEC:  r_sec  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_cfg_err;
    assign w_cfg_err = (r_cols < 9'd3) || (r_cols > 9'(MAX_GRID)) || (r_rows < 9'd2) ||
                       (r_rows > 9'(MAX_GRID)) || (r_rad == '0) || (r_sec == '0) ||
                       ((r_kind == KIND_TORUS) && (r_sec >= r_rad));

    // Pipeline control
    logic              w_en;
    logic              r_skid_v;
    logic              r_out_v;
    logic              r_in_v;
    logic [GRID_W-1:0] r_in_col;
    logic [GRID_W-1:0] r_in_row;
    logic              r_vld [P_LAT];

    assign w_en            = !r_skid_v;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            for (int k = 0; k < P_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_in_v   <= i_s_axis_tvalid;
            r_vld[0] <= r_in_v;
            for (int k = 1; k < P_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_col <= i_s_axis_tdata[GRID_W-1:0];
            r_in_row <= i_s_axis_tdata[2*GRID_W-1:GRID_W];
        end
    end

    // Angle units
    logic [DIV_M_W-1:0] w_m_col;
    logic [DIV_M_W-1:0] w_m_row;
    t_nrm               w_c;
    t_nrm               w_s;
    t_nrm               w_lc;
    t_nrm               w_ls;

    assign w_m_col = {r_in_col, 2'b00};
    assign w_m_row = (r_kind == KIND_TORUS) ? {r_in_row, 2'b00} : {1'b0, r_in_row, 1'b0};

    psv_trig u_trig_col (
        .i_clk(i_clk), .i_en(w_en), .i_m(w_m_col), .i_den(r_cols),
        .o_cos(w_c), .o_sin(w_s)
    );

    psv_trig u_trig_row (
        .i_clk(i_clk), .i_en(w_en), .i_m(w_m_row), .i_den(r_rows),
        .o_cos(w_lc), .o_sin(w_ls)
    );

    // Linear terms, texture numerators and slot
    logic signed [11:0]    w_nx;
    logic signed [11:0]    w_ny;
    logic [10:0]           w_nx_abs;
    logic [10:0]           w_ny_abs;
    logic [9:0]            w_denf;
    logic [LIN_NUM_W-1:0]  w_prodx;
    logic [LIN_NUM_W-1:0]  w_prodf;
    logic [18:0]           w_slot;
    logic [LIN_NUM_W-1:0]  r0_numx;
    logic [LIN_NUM_W-1:0]  r0_numf;
    logic [TEX_NUM_W-1:0]  r0_numu;
    logic [TEX_NUM_W-1:0]  r0_numv;
    logic [9:0]            r0_denf;
    logic [SIDE_W-1:0]     r0_side;

    assign w_nx     = $signed({2'b00, r_in_col, 1'b0}) - $signed({3'b000, r_cols});
    assign w_ny     = $signed({3'b000, r_rows}) - $signed({2'b00, r_in_row, 1'b0});
    assign w_nx_abs = w_nx[11] ? 11'(-w_nx) : w_nx[10:0];
    assign w_ny_abs = w_ny[11] ? 11'(-w_ny) : w_ny[10:0];
    assign w_denf   = (r_kind == KIND_TUBE) ? {r_rows, 1'b0} : {1'b0, r_rows};
    assign w_prodx  = w_nx_abs * r_rad;
    assign w_prodf  = w_ny_abs * r_sec;
    assign w_slot   = 19'(r_in_row) * 19'({1'b0, r_cols} + 10'd1) + 19'(r_in_col);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_numx <= w_prodx + LIN_NUM_W'(r_cols >> 1);
            r0_numf <= w_prodf + LIN_NUM_W'(w_denf >> 1);
            r0_numu <= {r_in_col, 16'd0} + TEX_NUM_W'(r_cols >> 1);
            r0_numv <= {r_in_row, 16'd0} + TEX_NUM_W'(r_rows >> 1);
            r0_denf <= w_denf;
            r0_side <= {w_nx[11], w_ny[11],
                        (w_slot > 19'(SLOT_MAX)) ? SLOT_MAX : w_slot[SLOT_W-1:0]};
        end
    end

    logic [LIN_NUM_W-1:0] w_qx;
    logic [LIN_NUM_W-1:0] w_qf;
    logic [TEX_NUM_W-1:0] w_qu;
    logic [TEX_NUM_W-1:0] w_qv;

    psv_div #(.NUM_W(LIN_NUM_W), .DEN_W(GRID_W)) u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num(r0_numx), .i_den(r_cols),
        .o_quo(w_qx), .o_rem(), .o_den()
    );
    psv_div #(.NUM_W(LIN_NUM_W), .DEN_W(10)) u_div_f (
        .i_clk(i_clk), .i_en(w_en), .i_num(r0_numf), .i_den(r0_denf),
        .o_quo(w_qf), .o_rem(), .o_den()
    );
    psv_div #(.NUM_W(TEX_NUM_W), .DEN_W(GRID_W)) u_div_u (
        .i_clk(i_clk), .i_en(w_en), .i_num(r0_numu), .i_den(r_cols),
        .o_quo(w_qu), .o_rem(), .o_den()
    );
    psv_div #(.NUM_W(TEX_NUM_W), .DEN_W(GRID_W)) u_div_v (
        .i_clk(i_clk), .i_en(w_en), .i_num(r0_numv), .i_den(r_rows),
        .o_quo(w_qv), .o_rem(), .o_den()
    );

    logic [TEX_W-1:0]       w_tu;
    logic [TEX_W-1:0]       w_tv;
    logic [2*TEX_W-1:0]     w_tex_d;
    logic [2*LIN_NUM_W-1:0] w_lin_d;
    logic [SIDE_W-1:0]      w_side_d;

    assign w_tu = (w_qu > TEX_NUM_W'(TEX_ONE)) ? TEX_ONE : w_qu[TEX_W-1:0];
    assign w_tv = (w_qv > TEX_NUM_W'(TEX_ONE)) ? TEX_ONE : w_qv[TEX_W-1:0];

    psv_delay #(.WIDTH(2*TEX_W), .DEPTH(TEX_DLY)) u_dly_tex (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_tv, w_tu}), .o_q(w_tex_d)
    );
    psv_delay #(.WIDTH(2*LIN_NUM_W), .DEPTH(LIN_DLY)) u_dly_lin (
        .i_clk(i_clk), .i_en(w_en), .i_d({w_qf, w_qx}), .o_q(w_lin_d)
    );
    psv_delay #(.WIDTH(SIDE_W), .DEPTH(SIDE_DLY)) u_dly_side (
        .i_clk(i_clk), .i_en(w_en), .i_d(r0_side), .o_q(w_side_d)
    );

    // First product stage: normals and torus ring radius
    t_nrm               w_a;
    logic signed [63:0] w_pac;
    logic signed [63:0] w_pas;
    logic signed [63:0] w_psec;
    logic signed [63:0] w_ring;
    t_nrm               r1_nx;
    t_nrm               r1_ny;
    t_nrm               r1_nz;
    t_nrm               r1_c;
    t_nrm               r1_s;
    t_nrm               r1_ts;
    logic signed [26:0] r1_ring;

    assign w_a    = (r_kind == KIND_SPHERE) ? w_ls : w_lc;
    assign w_pac  = w_a * w_c;
    assign w_pas  = w_a * w_s;
    assign w_psec = $signed({1'b0, r_sec}) * w_lc;
    assign w_ring = $signed({40'd0, r_rad}) + mulq(w_psec);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            unique case (r_kind)
                KIND_SPHERE: begin
                    r1_nx <= clamp_nrm(mulq(w_pac));
                    r1_ny <= w_lc;
                    r1_nz <= clamp_nrm(mulq(w_pas));
                end
                KIND_TORUS: begin
                    r1_nx <= clamp_nrm(mulq(w_pac));
                    r1_ny <= -w_ls;
                    r1_nz <= clamp_nrm(mulq(w_pas));
                end
                KIND_TUBE: begin
                    r1_nx <= w_c;
                    r1_ny <= '0;
                    r1_nz <= w_s;
                end
                KIND_PLANE: begin
                    r1_nx <= '0;
                    r1_ny <= ONE_Q;
                    r1_nz <= '0;
                end
                default: begin
                    r1_nx <= '0;
                    r1_ny <= '0;
                    r1_nz <= '0;
                end
            endcase
            r1_c    <= w_c;
            r1_s    <= w_s;
            r1_ts   <= w_ls;
            r1_ring <= w_ring[26:0];
        end
    end

    // Second product stage: positions
    logic signed [26:0] w_ax;
    logic signed [26:0] w_ay;
    t_nrm               w_bx;
    t_nrm               w_by;
    t_nrm               w_bz;
    logic signed [63:0] w_px;
    logic signed [63:0] w_py;
    logic signed [63:0] w_pz;
    logic signed [63:0] w_mx;
    logic signed [63:0] w_my;
    logic signed [63:0] w_mz;
    logic signed [27:0] r2_px;
    logic signed [27:0] r2_py;
    logic signed [27:0] r2_pz;
    t_nrm               r2_nx;
    t_nrm               r2_ny;
    t_nrm               r2_nz;

    assign w_ax = (r_kind == KIND_TORUS) ? r1_ring : $signed({3'b000, r_rad});
    assign w_ay = (r_kind == KIND_TORUS) ? $signed({3'b000, r_sec}) : $signed({3'b000, r_rad});
    assign w_bx = (r_kind == KIND_TORUS) ? r1_c : r1_nx;
    assign w_bz = (r_kind == KIND_TORUS) ? r1_s : r1_nz;
    assign w_by = (r_kind == KIND_TORUS) ? r1_ts : r1_ny;
    assign w_px = w_ax * w_bx;
    assign w_py = w_ay * w_by;
    assign w_pz = w_ax * w_bz;
    assign w_mx = mulq(w_px);
    assign w_my = mulq(w_py);
    assign w_mz = mulq(w_pz);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_px <= w_mx[27:0];
            r2_py <= (r_kind == KIND_TORUS) ? -w_my[27:0] : w_my[27:0];
            r2_pz <= w_mz[27:0];
            r2_nx <= r1_nx;
            r2_ny <= r1_ny;
            r2_nz <= r1_nz;
        end
    end

    // Final stage: select, saturate, pack
    logic signed [63:0]      w_linx;
    logic signed [63:0]      w_linf;
    logic signed [63:0]      w_selx;
    logic signed [63:0]      w_sely;
    logic signed [63:0]      w_selz;
    logic [OUT_DATA_W-1:0]   n_p_data;
    logic [OUT_DATA_W-1:0]   r_p_data;
    logic                    r_p_err;

    assign w_linx = w_side_d[SIDE_W-1] ? -$signed({30'd0, w_lin_d[LIN_NUM_W-1:0]})
                                       : $signed({30'd0, w_lin_d[LIN_NUM_W-1:0]});
    assign w_linf = w_side_d[SIDE_W-2] ? -$signed({30'd0, w_lin_d[2*LIN_NUM_W-1:LIN_NUM_W]})
                                       : $signed({30'd0, w_lin_d[2*LIN_NUM_W-1:LIN_NUM_W]});

    always_comb begin
        w_selx = r2_px;
        w_sely = r2_py;
        w_selz = r2_pz;
        unique case (r_kind)
            KIND_TUBE: begin
                w_sely = w_linf;
            end
            KIND_PLANE: begin
                w_selx = w_linx;
                w_sely = '0;
                w_selz = w_linf;
            end
            default: ;
        endcase
        if (w_cfg_err) begin
            n_p_data = '0;
        end else begin
            n_p_data = {1'b0, w_side_d[SLOT_W-1:0], w_tex_d[2*TEX_W-1:TEX_W],
                        w_tex_d[TEX_W-1:0], r2_nz, r2_ny, r2_nx,
                        clamp_pos(w_selz), clamp_pos(w_sely), clamp_pos(w_selx)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_data <= n_p_data;
            r_p_err  <= w_cfg_err;
        end
    end

    // Output register with a skid register behind it
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_err;
    logic [OUT_DATA_W-1:0] r_skid_data;
    logic                  r_skid_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_axis_tready) begin
                r_out_data <= r_skid_data;
                r_out_err  <= r_skid_err;
                r_skid_v   <= 1'b0;
            end
        end else if (r_vld[P_LAT-1]) begin
            if (!r_out_v || i_m_axis_tready) begin
                r_out_data <= r_p_data;
                r_out_err  <= r_p_err;
                r_out_v    <= 1'b1;
            end else begin
                r_skid_data <= r_p_data;
                r_skid_err  <= r_p_err;
                r_skid_v    <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_err;

    `PSV_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `PSV_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n,
        r_vld[P_LAT-1] && !r_skid_v && r_out_v && !i_m_axis_tready, r_skid_v)
    `PSV_ASSERT_IMP(a_err_zero_data, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0)
endmodule

>>> tb/psv_checker.sv
// Checker for the parametric surface vertex block: predicts each vertex and compares.
`timescale 1ns / 1ps
module psv_checker
    import psv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tuser,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    typedef struct {
        logic [OUT_DATA_W-1:0] data;
        logic                  err;
    } vertex_t;

    localparam int FIELD_W [9] = '{26, 26, 26, 18, 18, 18, 17, 17, 17};
    localparam string FIELD_NAME [9] = '{"pos_x", "pos_y", "pos_z", "nrm_x", "nrm_y",
                                         "nrm_z", "tex_u", "tex_v", "vertex_slot"};
    localparam longint ATAN_TBL [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                         512, 256, 128, 64, 32, 16, 8, 4, 2};
    localparam longint Q_ONE = 65536;

    logic [1:0]  shape_kind;
    logic [8:0]  grid_cols;
    logic [8:0]  grid_rows;
    logic [23:0] main_radius;
    logic [23:0] second_size;
    vertex_t     vertex_queue[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = vertex_queue.size();

    // Rounded division, ties away from zero; d is positive.
    function automatic longint round_div(input longint n, input longint d);
        if (n >= 0) begin
            return (n + d / 2) / d;
        end
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint limit(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return round_div(a * b, Q_ONE);
    endfunction

    // Cosine and sine of a quarter turn times m/den, via quadrant fold and CORDIC.
    function automatic void quarter_sincos(input longint m, input longint den,
                                           output longint cos_v, output longint sin_v);
        longint quad, rem, ang, x, y, dx, dy, cx, sx;
        quad = (m / den) & 3;
        rem  = m % den;
        ang  = round_div(rem * 102944, den);
        x    = 652032875;
        y    = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (ang >= 0) begin
                x = x - dx; y = y + dy; ang = ang - ATAN_TBL[i];
            end else begin
                x = x + dx; y = y - dy; ang = ang + ATAN_TBL[i];
            end
        end
        cx = limit(round_div(x, 64'sd1 << 14), -Q_ONE, Q_ONE);
        sx = limit(round_div(y, 64'sd1 << 14), -Q_ONE, Q_ONE);
        case (quad)
            0: begin cos_v = cx;  sin_v = sx;  end
            1: begin cos_v = -sx; sin_v = cx;  end
            2: begin cos_v = -cx; sin_v = -sx; end
            default: begin cos_v = sx; sin_v = -cx; end
        endcase
    endfunction

    function automatic vertex_t vertex_predict(input longint col, input longint row);
        vertex_t v;
        longint  cols, rows, rad, sec, c, s, lc, ls, ring;
        longint  pos[3], nrm[3];
        logic [63:0] f;
        cols = grid_cols; rows = grid_rows; rad = main_radius; sec = second_size;
        v.data = '0;
        v.err  = 1'b0;
        pos = '{0, 0, 0};
        nrm = '{0, 0, 0};
        if (cols < 3 || cols > MAX_GRID || rows < 2 || rows > MAX_GRID || rad == 0 ||
            sec == 0 || (shape_kind == KIND_TORUS && sec >= rad)) begin
            v.err = 1'b1;
            return v;
        end
        case (shape_kind)
            KIND_SPHERE: begin
                quarter_sincos(4 * col, cols, c, s);
                quarter_sincos(2 * row, rows, lc, ls);
                nrm[0] = limit(fix_mul(ls, c), -Q_ONE, Q_ONE);
                nrm[1] = lc;
                nrm[2] = limit(fix_mul(ls, s), -Q_ONE, Q_ONE);
                for (int i = 0; i < 3; i++) pos[i] = fix_mul(rad, nrm[i]);
            end
            KIND_TORUS: begin
                quarter_sincos(4 * col, cols, c, s);
                quarter_sincos(4 * row, rows, lc, ls);
                ring   = rad + fix_mul(sec, lc);
                pos[0] = fix_mul(ring, c);
                pos[1] = -fix_mul(sec, ls);
                pos[2] = fix_mul(ring, s);
                nrm[0] = limit(fix_mul(lc, c), -Q_ONE, Q_ONE);
                nrm[1] = -ls;
                nrm[2] = limit(fix_mul(lc, s), -Q_ONE, Q_ONE);
            end
            KIND_TUBE: begin
                quarter_sincos(4 * col, cols, c, s);
                pos[0] = fix_mul(rad, c);
                pos[1] = round_div((rows - 2 * row) * sec, 2 * rows);
                pos[2] = fix_mul(rad, s);
                nrm[0] = c;
                nrm[2] = s;
            end
            default: begin
                pos[0] = round_div((2 * col - cols) * rad, cols);
                pos[2] = round_div((rows - 2 * row) * sec, rows);
                nrm[1] = Q_ONE;
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            f = limit(pos[i], -33554432, 33554431);
            v.data[26*i +: 26] = f[25:0];
            f = limit(nrm[i], -Q_ONE, Q_ONE);
            v.data[78 + 18*i +: 18] = f[17:0];
        end
        f = limit(round_div(col * Q_ONE, cols), 0, Q_ONE);
        v.data[132 +: 17] = f[16:0];
        f = limit(round_div(row * Q_ONE, rows), 0, Q_ONE);
        v.data[149 +: 17] = f[16:0];
        f = limit(row * (cols + 1) + col, 0, 131071);
        v.data[166 +: 17] = f[16:0];
        return v;
    endfunction

    // The failure count is updated with blocking assignments, since one beat
    // may carry several mismatching fields.
    always @(posedge i_clk) begin
        vertex_t want;
        int      off;
        logic [63:0] e_f, a_f;
        if (!i_rst_n) begin
            shape_kind  <= KIND_SPHERE;
            grid_cols   <= 9'd3;
            grid_rows   <= 9'd2;
            main_radius <= 24'd65536;
            second_size <= 24'd32768;
            vertex_queue.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KIND: shape_kind  <= i_cfg_data[1:0];
                    CFG_COLS: grid_cols   <= i_cfg_data[8:0];
                    CFG_ROWS: grid_rows   <= i_cfg_data[8:0];
                    CFG_RAD:  main_radius <= i_cfg_data;
                    CFG_SEC:  second_size <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                vertex_queue.push_back(vertex_predict(i_s_tdata[8:0], i_s_tdata[17:9]));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (vertex_queue.size() == 0) begin
                    $display("%0t: unexpected vertex beat %h", $time, i_m_tdata);
                    fails = fails + 1;
                end else begin
                    want = vertex_queue.pop_front();
                    if (want.err !== i_m_tuser) begin
                        $display("%0t: config_error expected %0b actual %0b",
                                 $time, want.err, i_m_tuser);
                        fails = fails + 1;
                    end
                    off = 0;
                    for (int i = 0; i < 9; i++) begin
                        e_f = 64'((want.data >> off) & ((64'd1 << FIELD_W[i]) - 1));
                        a_f = 64'((i_m_tdata >> off) & ((64'd1 << FIELD_W[i]) - 1));
                        if (e_f !== a_f) begin
                            $display("%0t: %s expected %h actual %h",
                                     $time, FIELD_NAME[i], e_f, a_f);
                            fails = fails + 1;
                        end
                        off = off + FIELD_W[i];
                    end
                end
            end
        end
    end
endmodule

>>> tb/tb.sv
// Testbench top: grid point stimulus, configuration phases and the verdict.
`timescale 1ns / 1ps
module tb;
    import psv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [2:0]            cfg_idx;
    logic [CFG_W-1:0]      cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycle_count;
    int                    burst_left;
    logic [8:0]            cur_cols;
    logic [8:0]            cur_rows;

    parametric_surface_vertex u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .o_m_axis_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    psv_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** parametric_surface_vertex: FAILED **");
            $finish;
        end
    end

    // Output side: the stall style is picked anew at random, with one long hold-off
    // that fills the pipeline and backs up the input.
    initial begin
        int style;
        int n;
        n = 0;
        style = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            n++;
            if (n % 200 == 0) style = $urandom_range(0, 3);
            if (n >= 3000 && n < 3600) begin
                m_tready <= 1'b0;
            end else begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 0);
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic send_point(input logic [8:0] col, input logic [8:0] row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, row, col};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // Lets the pipeline drain; up to the latency is allowed for a result still in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_surface(input logic [1:0] kind, input logic [8:0] cols,
                               input logic [8:0] rows, input logic [23:0] rad,
                               input logic [23:0] sec);
        drain();
        write_setting(CFG_KIND, kind);
        write_setting(CFG_COLS, cols);
        write_setting(CFG_ROWS, rows);
        write_setting(CFG_RAD, rad);
        write_setting(CFG_SEC, sec);
        cfg_we <= 1'b0;
        cur_cols = cols;
        cur_rows = rows;
    endtask

    // Corners of the grid, its middle and a point past its far edge.
    task automatic corner_points();
        send_point(0, 0);
        send_point(cur_cols, cur_rows);
        send_point(cur_cols / 2, cur_rows / 2);
        send_point(9'd511, 9'd511);
    endtask

    function automatic logic [8:0] pick_size(input int lo);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 9'($urandom_range(0, 511));
        if (r < 3) return 9'(lo);
        if (r < 5) return 9'd256;
        if (r < 10) return 9'($urandom_range(lo, 12));
        return 9'($urandom_range(lo, 256));
    endfunction

    function automatic logic [23:0] pick_length();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 24'd0;
        if (r == 1) return 24'd1;
        if (r == 2) return 24'hFFFFFF;
        if (r < 6) return 24'($urandom_range(1, 24'hFFFFFF));
        return 24'($urandom_range(1, 24'h0FFFFF));
    endfunction

    initial begin
        logic [1:0]  kind;
        logic [23:0] rad;
        logic [23:0] sec;
        int          count;
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_we      <= 1'b0;
        cfg_idx     <= CFG_KIND;
        cfg_data    <= '0;
        cycle_count <= 0;
        burst_left  = 0;
        cur_cols    = 9'd3;
        cur_rows    = 9'd2;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration, then extreme and invalid settings.
        corner_points();
        set_surface(KIND_SPHERE, 9'd256, 9'd256, 24'hFFFFFF, 24'hFFFFFF);
        corner_points();
        set_surface(KIND_TORUS, 9'd3, 9'd2, 24'hFFFFFF, 24'hFFFFFE);
        corner_points();
        set_surface(KIND_TUBE, 9'd3, 9'd256, 24'd1, 24'hFFFFFF);
        corner_points();
        set_surface(KIND_PLANE, 9'd256, 9'd2, 24'hFFFFFF, 24'd1);
        corner_points();
        set_surface(KIND_TORUS, 9'd8, 9'd8, 24'd65536, 24'd65536);
        send_point(1, 1);
        set_surface(KIND_SPHERE, 9'd2, 9'd257, 24'd0, 24'd0);
        send_point(2, 2);

        count = 0;
        while (count < 2000) begin
            kind = 2'($urandom_range(0, 3));
            rad  = pick_length();
            sec  = pick_length();
            // Mostly a valid torus, with the tube radius below the main radius.
            if (kind == KIND_TORUS && $urandom_range(0, 5) != 0 && rad > 1) begin
                sec = 24'($urandom_range(1, rad - 1));
            end
            set_surface(kind, pick_size(3), pick_size(2), rad, sec);
            repeat ($urandom_range(100, 300)) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_point(9'($urandom), 9'($urandom));
                end else begin
                    send_point(9'($urandom_range(0, cur_cols)),
                               9'($urandom_range(0, cur_rows)));
                end
                count++;
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("** parametric_surface_vertex: PASSED **");
        end else begin
            $display("** parametric_surface_vertex: FAILED **");
        end
        $finish;
    end
endmodule
